// File: design/lidar_sector_steering_macros.svh
// Assertion helpers for the lidar sector steering block.
`ifndef LIDAR_SECTOR_STEERING_MACROS_SVH
`define LIDAR_SECTOR_STEERING_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define LSS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lss check failed: same cycle");
// Next-cycle implication, checked out of reset.
`define LSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lss check failed: next cycle");
`else
`define LSS_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define LSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: design/lss_pkg.sv
package lss_pkg;

    localparam int MAX_POINTS = 512;

    localparam logic [9:0] COUNT_CAP = (MAX_POINTS > 1023) ? 10'd1023 : 10'(MAX_POINTS);

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_MIN_RANGE   = 3'd0;
    localparam logic [2:0] REG_NEAR_RADIUS = 3'd1;
    localparam logic [2:0] REG_FAR_RANGE   = 3'd2;
    localparam logic [2:0] REG_DEADBAND    = 3'd3;
    localparam logic [2:0] REG_PROP_GAIN   = 3'd4;
    localparam logic [2:0] REG_DERIV_GAIN  = 3'd5;
    localparam logic [2:0] REG_STEER_LIMIT = 3'd6;

    localparam logic [15:0] RST_MIN_RANGE   = 16'd50;
    localparam logic [15:0] RST_NEAR_RADIUS = 16'd800;
    localparam logic [15:0] RST_FAR_RANGE   = 16'd3000;
    localparam logic [9:0]  RST_DEADBAND    = 10'd8;
    localparam logic [15:0] RST_PROP_GAIN   = 16'd47;
    localparam logic [15:0] RST_DERIV_GAIN  = 16'd2360;
    localparam logic [15:0] RST_STEER_LIMIT = 16'd1700;

    // Bearing bounds in tenths of a degree
    localparam logic signed [11:0] ANG_ZERO    = 12'sd0;
    localparam logic signed [11:0] ANG_QUARTER = 12'sd900;
    localparam logic signed [11:0] ANG_HALF    = 12'sd1800;

    localparam logic [12:0] SPEED_SLOW = 13'd4700;
    localparam logic [12:0] SPEED_FAST = 13'd7000;

    localparam logic [9:0] ZONE_LB_MAX = 10'd30;
    localparam logic [9:0] ZONE_FF_MIN = 10'd40;

    localparam logic signed [30:0] RATE_OUT_MAX = 31'sd2047;
    localparam logic signed [30:0] RATE_OUT_MIN = -31'sd2048;

    typedef enum logic [2:0] {
        SECT_NONE,
        SECT_RIGHT,
        SECT_LEFT,
        SECT_LEFT_BACK,
        SECT_RIGHT_BACK,
        SECT_FAR_FRONT
    } sector_t;

    typedef struct packed {
        logic signed [11:0] angle_decideg;
        logic [15:0]        distance_mm;
        logic               last_point;
    } point_t;

    typedef struct packed {
        logic [12:0]        linear_speed_milli;
        logic signed [11:0] angular_rate_milli;
        logic               harvest_zone;
    } result_t;

    // Scan-end data handed to the steering unit
    typedef struct packed {
        logic signed [10:0] err;
        logic signed [11:0] delta;
        logic               zone;
    } scan_end_t;

    typedef struct packed {
        logic [9:0]  deadband;
        logic [15:0] prop_gain;
        logic [15:0] deriv_gain;
        logic [15:0] steer_limit;
    } pd_cfg_t;

endpackage

// File: design/lss_sector_classify.sv
module lss_sector_classify (
    input  lss_pkg::point_t  point,
    input  logic [15:0]      min_range_mm,
    input  logic [15:0]      near_radius_mm,
    input  logic [15:0]      far_range_mm,
    output lss_pkg::sector_t sector
);

    logic near_lim;
    logic near_ok;
    logic signed [11:0] a;
    logic [15:0] d;

    assign a        = point.angle_decideg;
    assign d        = point.distance_mm;
    assign near_lim = d < near_radius_mm;
    assign near_ok  = (min_range_mm < d) && near_lim;

    // First match wins
    always_comb begin
        if (near_ok && a > lss_pkg::ANG_ZERO && a < lss_pkg::ANG_QUARTER) begin
            sector = lss_pkg::SECT_RIGHT;
        end else if (near_ok && a > lss_pkg::ANG_QUARTER && a < lss_pkg::ANG_HALF) begin
            sector = lss_pkg::SECT_LEFT;
        end else if (near_lim && a > -lss_pkg::ANG_HALF && a < -lss_pkg::ANG_QUARTER) begin
            sector = lss_pkg::SECT_LEFT_BACK;
        end else if (near_ok && a > -lss_pkg::ANG_QUARTER && a < lss_pkg::ANG_ZERO) begin
            sector = lss_pkg::SECT_RIGHT_BACK;
        end else if (d > far_range_mm && a > lss_pkg::ANG_ZERO && a < lss_pkg::ANG_HALF) begin
            sector = lss_pkg::SECT_FAR_FRONT;
        end else begin
            sector = lss_pkg::SECT_NONE;
        end
    end

endmodule

// File: design/lss_pd_steer.sv
module lss_pd_steer (
    input  logic               aclk,
    input  logic               aresetn,
    input  lss_pkg::pd_cfg_t   cfg,
    input  logic               op_valid,
    output logic               op_ready,
    input  lss_pkg::scan_end_t op,
    output logic               m_valid,
    input  logic               m_ready,
    output lss_pkg::result_t   m_data
);

    logic signed [11:0] err_x;
    logic signed [11:0] db_s;
    logic signed [11:0] p_opnd;
    logic signed [12:0] d_opnd;
    logic [12:0]        speed;
    logic signed [28:0] p_wide;
    logic signed [28:0] kp_wide;
    logic signed [29:0] d_wide;
    logic signed [29:0] kd_wide;

    logic               prd_vld_reg;
    logic signed [28:0] kp_prod_reg;
    logic signed [29:0] kd_prod_reg;
    logic [12:0]        speed_reg;
    logic               zone_reg;

    logic signed [30:0] rate_sum;
    logic signed [30:0] lim_s;
    logic signed [30:0] rate_lim;
    logic signed [30:0] rate_sat;

    logic               m_vld_reg;
    lss_pkg::result_t   m_data_reg;
    logic               out_ready;
    logic               op_take;

    assign out_ready = !m_vld_reg || m_ready;
    assign op_ready  = !prd_vld_reg || out_ready;
    assign op_take   = op_valid && op_ready;

    // Deadband test and operand selection
    always_comb begin
        err_x = 12'(op.err);
        db_s  = $signed({2'b00, cfg.deadband});
        if (err_x < -db_s) begin
            p_opnd = -(err_x + db_s);
            d_opnd = 13'(op.delta);
            speed  = lss_pkg::SPEED_SLOW;
        end else if (err_x > db_s) begin
            p_opnd = db_s - err_x;
            d_opnd = -13'(op.delta);
            speed  = lss_pkg::SPEED_SLOW;
        end else begin
            p_opnd = '0;
            d_opnd = '0;
            speed  = lss_pkg::SPEED_FAST;
        end
        p_wide  = 29'(p_opnd);
        kp_wide = $signed({13'd0, cfg.prop_gain});
        d_wide  = 30'(d_opnd);
        kd_wide = $signed({14'd0, cfg.deriv_gain});
    end

    // Sum and saturate: first the steering limit, then the output range
    always_comb begin
        rate_sum = 31'(kp_prod_reg) + 31'(kd_prod_reg);
        lim_s    = $signed({15'd0, cfg.steer_limit});
        if (rate_sum > lim_s) begin
            rate_lim = lim_s;
        end else if (rate_sum < -lim_s) begin
            rate_lim = -lim_s;
        end else begin
            rate_lim = rate_sum;
        end
        if (rate_lim > lss_pkg::RATE_OUT_MAX) begin
            rate_sat = lss_pkg::RATE_OUT_MAX;
        end else if (rate_lim < lss_pkg::RATE_OUT_MIN) begin
            rate_sat = lss_pkg::RATE_OUT_MIN;
        end else begin
            rate_sat = rate_lim;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prd_vld_reg <= 1'b0;
            m_vld_reg   <= 1'b0;
        end else begin
            if (op_ready) begin
                prd_vld_reg <= op_valid;
            end
            if (out_ready) begin
                m_vld_reg <= prd_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (op_take) begin
            kp_prod_reg <= p_wide * kp_wide;
            kd_prod_reg <= d_wide * kd_wide;
            speed_reg   <= speed;
            zone_reg    <= op.zone;
        end
        if (out_ready && prd_vld_reg) begin
            m_data_reg.linear_speed_milli <= speed_reg;
            m_data_reg.angular_rate_milli <= rate_sat[11:0];
            m_data_reg.harvest_zone       <= zone_reg;
        end
    end

    assign m_valid = m_vld_reg;
    assign m_data  = m_data_reg;

endmodule

// File: design/lidar_sector_steering.sv
// Lidar sector steering.
// Points stream in on the s_ channel (valid/ready), one transaction per point:
// bearing in tenths of a degree, range in mm, and a flag on the last point of
// a scan. Each point bumps at most one sector counter (near-right, near-left,
// near-left-back, far-front). The last point of a scan closes the scan and
// yields one transaction on the m_ channel: speed, clamped PD steering rate
// and the sticky harvest-zone flag. Other points yield nothing.
// Throughput: one point per cycle while no last point waits for room in the
// scan-end register; the sector counters take a point in the cycle after it
// is accepted, so points follow each other without gaps.
// Scan result path: the input register loads at the accepting edge, then the
// scan-end register, the product register and the output register (m_valid) follow.
// Stalls: while m_ready is low the result waits in the output register; the
// two stages behind it fill up, and s_ready drops only when a last point
// finds no free slot. Points that do not end a scan keep flowing.
// Reset (aresetn low, synchronous): counters, previous error and zone flag
// clear, registers return to their defaults, all stages empty.
// Registers sit on an APB-style port at byte address 4*index; pready is tied high.

`include "lidar_sector_steering_macros.svh"

module lidar_sector_steering (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lss_pkg::point_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output lss_pkg::result_t m_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers
    logic [15:0] min_range_reg;
    logic [15:0] near_radius_reg;
    logic [15:0] far_range_reg;
    logic [9:0]  deadband_reg;
    logic [15:0] prop_gain_reg;
    logic [15:0] deriv_gain_reg;
    logic [15:0] steer_limit_reg;
    logic        cfg_write;

    // Input register
    logic             in_vld_reg;
    lss_pkg::point_t  in_reg;
    logic             s_take;
    logic             in_adv;
    logic             scan_end;

    // Sector counters and scan state
    lss_pkg::sector_t sector;
    logic [9:0]       right_cnt_reg,  right_cnt_next;
    logic [9:0]       left_cnt_reg,   left_cnt_next;
    logic [9:0]       lback_cnt_reg,  lback_cnt_next;
    logic [9:0]       ffront_cnt_reg, ffront_cnt_next;
    logic signed [10:0] prev_err_reg;
    logic signed [10:0] err_next;
    logic signed [11:0] delta_next;
    logic             zone_flag_reg;
    logic             zone_next;
    logic             cnt_in_cap;
    logic             cnt_all_zero;

    // Scan-end register feeding the steering unit
    logic               op_vld_reg;
    lss_pkg::scan_end_t op_reg;
    logic               op_ready;
    logic               b_ready;
    lss_pkg::pd_cfg_t   pd_cfg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_range_reg   <= lss_pkg::RST_MIN_RANGE;
            near_radius_reg <= lss_pkg::RST_NEAR_RADIUS;
            far_range_reg   <= lss_pkg::RST_FAR_RANGE;
            deadband_reg    <= lss_pkg::RST_DEADBAND;
            prop_gain_reg   <= lss_pkg::RST_PROP_GAIN;
            deriv_gain_reg  <= lss_pkg::RST_DERIV_GAIN;
            steer_limit_reg <= lss_pkg::RST_STEER_LIMIT;
        end else if (cfg_write) begin
            case (paddr[4:2])
                lss_pkg::REG_MIN_RANGE:   min_range_reg   <= pwdata[15:0];
                lss_pkg::REG_NEAR_RADIUS: near_radius_reg <= pwdata[15:0];
                lss_pkg::REG_FAR_RANGE:   far_range_reg   <= pwdata[15:0];
                lss_pkg::REG_DEADBAND:    deadband_reg    <= pwdata[9:0];
                lss_pkg::REG_PROP_GAIN:   prop_gain_reg   <= pwdata[15:0];
                lss_pkg::REG_DERIV_GAIN:  deriv_gain_reg  <= pwdata[15:0];
                lss_pkg::REG_STEER_LIMIT: steer_limit_reg <= pwdata[15:0];
                default: ; // unmapped index: drop the write
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            lss_pkg::REG_MIN_RANGE:   prdata = {16'd0, min_range_reg};
            lss_pkg::REG_NEAR_RADIUS: prdata = {16'd0, near_radius_reg};
            lss_pkg::REG_FAR_RANGE:   prdata = {16'd0, far_range_reg};
            lss_pkg::REG_DEADBAND:    prdata = {22'd0, deadband_reg};
            lss_pkg::REG_PROP_GAIN:   prdata = {16'd0, prop_gain_reg};
            lss_pkg::REG_DERIV_GAIN:  prdata = {16'd0, deriv_gain_reg};
            lss_pkg::REG_STEER_LIMIT: prdata = {16'd0, steer_limit_reg};
            default:                  prdata = '0;
        endcase
    end

    // Handshake: a point that does not end a scan always advances; a last
    // point advances only when the scan-end register has room.
    assign b_ready  = !op_vld_reg || op_ready;
    assign in_adv   = in_vld_reg && (!in_reg.last_point || b_ready);
    assign scan_end = in_adv && in_reg.last_point;
    assign s_ready  = !in_vld_reg || in_adv;
    assign s_take   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_reg <= s_data;
        end
    end

    lss_sector_classify u_classify (
        .point          (in_reg),
        .min_range_mm   (min_range_reg),
        .near_radius_mm (near_radius_reg),
        .far_range_mm   (far_range_reg),
        .sector         (sector)
    );

    // Saturating increments; right-back and unmatched points leave counters alone
    always_comb begin
        right_cnt_next  = right_cnt_reg;
        left_cnt_next   = left_cnt_reg;
        lback_cnt_next  = lback_cnt_reg;
        ffront_cnt_next = ffront_cnt_reg;
        case (sector)
            lss_pkg::SECT_RIGHT: begin
                if (right_cnt_reg < lss_pkg::COUNT_CAP) right_cnt_next = right_cnt_reg + 10'd1;
            end
            lss_pkg::SECT_LEFT: begin
                if (left_cnt_reg < lss_pkg::COUNT_CAP) left_cnt_next = left_cnt_reg + 10'd1;
            end
            lss_pkg::SECT_LEFT_BACK: begin
                if (lback_cnt_reg < lss_pkg::COUNT_CAP) lback_cnt_next = lback_cnt_reg + 10'd1;
            end
            lss_pkg::SECT_FAR_FRONT: begin
                if (ffront_cnt_reg < lss_pkg::COUNT_CAP) begin
                    ffront_cnt_next = ffront_cnt_reg + 10'd1;
                end
            end
            default: ;
        endcase
    end

    // Scan-end values use the counts with the last point already added
    assign err_next   = $signed({1'b0, left_cnt_next}) - $signed({1'b0, right_cnt_next});
    assign delta_next = 12'(err_next) - 12'(prev_err_reg);
    assign zone_next  = zone_flag_reg
                     || ((lback_cnt_next != 10'd0) && (lback_cnt_next < lss_pkg::ZONE_LB_MAX)
                         && (ffront_cnt_next > lss_pkg::ZONE_FF_MIN));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            right_cnt_reg  <= '0;
            left_cnt_reg   <= '0;
            lback_cnt_reg  <= '0;
            ffront_cnt_reg <= '0;
            prev_err_reg   <= '0;
            zone_flag_reg  <= 1'b0;
            op_vld_reg     <= 1'b0;
        end else begin
            if (scan_end) begin
                // close the scan: clear counters, keep error for the D term
                right_cnt_reg  <= '0;
                left_cnt_reg   <= '0;
                lback_cnt_reg  <= '0;
                ffront_cnt_reg <= '0;
                prev_err_reg   <= err_next;
                zone_flag_reg  <= zone_next;
            end else if (in_adv) begin
                right_cnt_reg  <= right_cnt_next;
                left_cnt_reg   <= left_cnt_next;
                lback_cnt_reg  <= lback_cnt_next;
                ffront_cnt_reg <= ffront_cnt_next;
            end
            if (scan_end) begin
                op_vld_reg <= 1'b1;
            end else if (op_ready) begin
                op_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_end) begin
            op_reg.err   <= err_next;
            op_reg.delta <= delta_next;
            op_reg.zone  <= zone_next;
        end
    end

    assign pd_cfg.deadband    = deadband_reg;
    assign pd_cfg.prop_gain   = prop_gain_reg;
    assign pd_cfg.deriv_gain  = deriv_gain_reg;
    assign pd_cfg.steer_limit = steer_limit_reg;

    lss_pd_steer u_pd (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (pd_cfg),
        .op_valid (op_vld_reg),
        .op_ready (op_ready),
        .op       (op_reg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    assign cnt_in_cap   = (right_cnt_reg <= lss_pkg::COUNT_CAP)
                       && (left_cnt_reg <= lss_pkg::COUNT_CAP)
                       && (lback_cnt_reg <= lss_pkg::COUNT_CAP)
                       && (ffront_cnt_reg <= lss_pkg::COUNT_CAP);
    assign cnt_all_zero = (right_cnt_reg == 10'd0) && (left_cnt_reg == 10'd0)
                       && (lback_cnt_reg == 10'd0) && (ffront_cnt_reg == 10'd0);

    `LSS_ASSERT_NOW(a_cnt_cap, aclk, aresetn, 1'b1, cnt_in_cap)
    `LSS_ASSERT_NEXT(a_scan_clear, aclk, aresetn, scan_end, cnt_all_zero && op_vld_reg)
    `LSS_ASSERT_NEXT(a_zone_sticky, aclk, aresetn, zone_flag_reg, zone_flag_reg)
    `LSS_ASSERT_NOW(a_stall_cause, aclk, aresetn, !s_ready, in_vld_reg && in_reg.last_point && op_vld_reg)

endmodule

// File: bench/lidar_sector_steering_test.sv
module lidar_sector_steering_test;
    import lss_pkg::*;

    // Zone thresholds on the scan-end counters.
    localparam logic [9:0] ZONE_BACK_LIMIT = 10'd30;
    localparam logic [9:0] ZONE_FRONT_MIN  = 10'd40;
    // Address that decodes to no register.
    localparam logic [2:0] REG_UNUSED = 3'd7;
    // Cycles to let pass after the last expected result before touching
    // the registers or ending the run; a margin, the block is idle by then.
    localparam int SETTLE_CYCLES = 10;

    typedef struct {
        point_t pt;
        bit     drain_first;
    } pending_point_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    point_t      s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    result_t     m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Local copy of the register file, updated as each write lands.
    logic [15:0] cfg_min = RST_MIN_RANGE;
    logic [15:0] cfg_near = RST_NEAR_RADIUS;
    logic [15:0] cfg_far = RST_FAR_RANGE;
    logic [9:0]  cfg_deadband = RST_DEADBAND;
    logic [15:0] cfg_kp = RST_PROP_GAIN;
    logic [15:0] cfg_kd = RST_DERIV_GAIN;
    logic [15:0] cfg_limit = RST_STEER_LIMIT;

    // Shadow of the per-scan sector state.
    logic [9:0]         cnt_right = '0;
    logic [9:0]         cnt_left = '0;
    logic [9:0]         cnt_left_back = '0;
    logic [9:0]         cnt_far_front = '0;
    logic signed [10:0] prev_err = '0;
    logic               zone_seen = 1'b0;

    pending_point_t point_queue[$];
    result_t        steer_expect[$];
    result_t        steer_want;

    int points_pushed = 0;
    int points_taken = 0;
    int mismatch_count = 0;
    int send_gap = 0;
    int send_calm = 0;
    int recv_stall = 0;
    int recv_calm = 0;

    lidar_sector_steering dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 aclk = ~aclk;

    // Saturating counter increment.
    function automatic logic [9:0] bumped(logic [9:0] c);
        return (c < COUNT_CAP) ? c + 10'd1 : c;
    endfunction

    // Advance the sector state by one accepted point. On the last point of a
    // scan, form the steering transaction and return 1.
    function automatic bit advance_sectors(input point_t p, output result_t r);
        int     a;
        int     d;
        bit     near_ok;
        longint err;
        longint delta;
        longint db;
        longint rate;
        a = $signed(p.angle_decideg);
        d = int'(p.distance_mm);
        near_ok = (int'(cfg_min) < d) && (d < int'(cfg_near));
        r = '0;

        // First matching sector wins; right-back swallows the point uncounted.
        if (near_ok && a > 0 && a < 900) begin
            cnt_right = bumped(cnt_right);
        end else if (near_ok && a > 900 && a < 1800) begin
            cnt_left = bumped(cnt_left);
        end else if (d < int'(cfg_near) && a > -1800 && a < -900) begin
            cnt_left_back = bumped(cnt_left_back);
        end else if (near_ok && a > -900 && a < 0) begin
        end else if (d > int'(cfg_far) && a > 0 && a < 1800) begin
            cnt_far_front = bumped(cnt_far_front);
        end

        if (!p.last_point) return 1'b0;

        err = longint'(cnt_left) - longint'(cnt_right);
        delta = err - longint'(prev_err);
        db = longint'(cfg_deadband);
        rate = 0;
        r.linear_speed_milli = SPEED_FAST;
        if (err < -db) begin
            r.linear_speed_milli = SPEED_SLOW;
            rate = -(err + db) * longint'(cfg_kp) + delta * longint'(cfg_kd);
        end else if (err > db) begin
            r.linear_speed_milli = SPEED_SLOW;
            rate = -(err - db) * longint'(cfg_kp) - delta * longint'(cfg_kd);
        end
        // Clamp to the programmed limit, then to what the output field holds.
        if (rate > longint'(cfg_limit)) rate = longint'(cfg_limit);
        else if (rate < -longint'(cfg_limit)) rate = -longint'(cfg_limit);
        if (rate > 2047) rate = 2047;
        else if (rate < -2048) rate = -2048;

        prev_err = 11'(err);
        if (cnt_left_back > 0 && cnt_left_back < ZONE_BACK_LIMIT &&
            cnt_far_front > ZONE_FRONT_MIN) begin
            zone_seen = 1'b1;
        end
        r.angular_rate_milli = 12'(rate);
        r.harvest_zone = zone_seen;

        cnt_right = '0;
        cnt_left = '0;
        cnt_left_back = '0;
        cnt_far_front = '0;
        return 1'b1;
    endfunction

    // Idle length: mostly none or short, now and then long, with calm
    // stretches of back-to-back traffic.
    function automatic int draw_gap(ref int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Driver: offer one point at a time, hold it until accepted, and score
    // each transaction as it is taken.
    always @(posedge aclk) begin
        result_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (advance_sectors(s_data, r)) steer_expect.push_back(r);
                points_taken++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (point_queue.size() != 0 &&
                             !(point_queue[0].drain_first && steer_expect.size() != 0)) begin
                    // A point marked drain_first waits until every pending
                    // result has come out.
                    s_data <= point_queue[0].pt;
                    s_valid <= 1'b1;
                    void'(point_queue.pop_front());
                    send_gap = draw_gap(send_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every result transaction with the oldest expectation,
    // and stall the result channel at random.
    always @(posedge aclk) begin
        int g;
        if (aresetn && m_valid && m_ready) begin
            if (steer_expect.size() == 0) begin
                $error("result transaction with nothing expected: speed %0d rate %0d zone %0d",
                       m_data.linear_speed_milli, $signed(m_data.angular_rate_milli),
                       m_data.harvest_zone);
                mismatch_count++;
            end else begin
                steer_want = steer_expect.pop_front();
                if (m_data.linear_speed_milli !== steer_want.linear_speed_milli) begin
                    $error("linear_speed_milli: expected %0d, actual %0d",
                           steer_want.linear_speed_milli, m_data.linear_speed_milli);
                    mismatch_count++;
                end
                if (m_data.angular_rate_milli !== steer_want.angular_rate_milli) begin
                    $error("angular_rate_milli: expected %0d, actual %0d",
                           $signed(steer_want.angular_rate_milli),
                           $signed(m_data.angular_rate_milli));
                    mismatch_count++;
                end
                if (m_data.harvest_zone !== steer_want.harvest_zone) begin
                    $error("harvest_zone: expected %0d, actual %0d",
                           steer_want.harvest_zone, m_data.harvest_zone);
                    mismatch_count++;
                end
            end
        end
        if (recv_stall > 0) begin
            recv_stall--;
            m_ready <= 1'b0;
        end else begin
            g = draw_gap(recv_calm);
            if (g > 0) begin
                recv_stall = g - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Register write: setup cycle, then access cycle. Junk in the upper
    // half of pwdata must be dropped by the block.
    task automatic reg_write(logic [2:0] idx, logic [15:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MIN_RANGE:   cfg_min = val;
            REG_NEAR_RADIUS: cfg_near = val;
            REG_FAR_RANGE:   cfg_far = val;
            REG_DEADBAND:    cfg_deadband = val[9:0];
            REG_PROP_GAIN:   cfg_kp = val;
            REG_DERIV_GAIN:  cfg_kd = val;
            REG_STEER_LIMIT: cfg_limit = val;
            default: ;
        endcase
    endtask

    task automatic apply_config(int mn, int nr, int fr, int db, int kp, int kd, int lim);
        reg_write(REG_MIN_RANGE, 16'(mn));
        reg_write(REG_NEAR_RADIUS, 16'(nr));
        reg_write(REG_FAR_RANGE, 16'(fr));
        reg_write(REG_DEADBAND, 16'(db));
        reg_write(REG_PROP_GAIN, 16'(kp));
        reg_write(REG_DERIV_GAIN, 16'(kd));
        reg_write(REG_STEER_LIMIT, 16'(lim));
    endtask

    // Wait until every point is taken and every result has arrived, then
    // let the pipeline settle.
    task automatic drain();
        while (points_taken != points_pushed || steer_expect.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic push_point(point_t p, bit drain_first);
        pending_point_t e;
        e.pt = p;
        e.drain_first = drain_first;
        point_queue.push_back(e);
        points_pushed++;
    endtask

    function automatic point_t make_point(int a, int d, bit last);
        point_t p;
        p.angle_decideg = 12'(a);
        p.distance_mm = 16'(d);
        p.last_point = last;
        return p;
    endfunction

    // One scan with fixed counts per sector, interleaved; needs the default
    // distance thresholds.
    task automatic push_scan(int n_back, int n_front, int n_right, int n_left);
        point_t scan_pts[$];
        int     top;
        top = n_back;
        if (n_front > top) top = n_front;
        if (n_right > top) top = n_right;
        if (n_left > top) top = n_left;
        for (int i = 0; i < top; i++) begin
            if (i < n_back) scan_pts.push_back(make_point(-1350, 400, 1'b0));
            if (i < n_front) scan_pts.push_back(make_point(450, 5000, 1'b0));
            if (i < n_right) scan_pts.push_back(make_point(450, 400, 1'b0));
            if (i < n_left) scan_pts.push_back(make_point(1350, 400, 1'b0));
        end
        scan_pts[$].last_point = 1'b1;
        foreach (scan_pts[i]) push_point(scan_pts[i], 1'b0);
    endtask

    // Distances sitting on the current thresholds, or anywhere at all.
    function automatic logic [15:0] boundary_dist();
        case ($urandom_range(0, 7))
            0: return cfg_min;
            1: return cfg_min + 16'd1;
            2: return cfg_near - 16'd1;
            3: return cfg_near;
            4: return cfg_far;
            5: return cfg_far + 16'd1;
            6: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic point_t draw_point(bit last);
        int          pick;
        int          a;
        logic [15:0] nd;
        logic [15:0] fd;
        if (int'(cfg_near) > int'(cfg_min) + 1 && $urandom_range(0, 9) < 8)
            nd = 16'($urandom_range(int'(cfg_min) + 1, int'(cfg_near) - 1));
        else
            nd = boundary_dist();
        if (cfg_far < 16'hFFFF && $urandom_range(0, 9) < 8)
            fd = 16'($urandom_range(int'(cfg_far) + 1, 65535));
        else
            fd = boundary_dist();
        pick = $urandom_range(0, 99);
        if (pick < 25) return make_point($urandom_range(1, 899), nd, last);
        if (pick < 50) return make_point($urandom_range(901, 1799), nd, last);
        if (pick < 62) return make_point(-int'($urandom_range(901, 1799)), nd, last);
        if (pick < 72) return make_point(-int'($urandom_range(1, 899)), nd, last);
        if (pick < 84) return make_point($urandom_range(1, 1799), fd, last);
        if (pick < 90) begin
            // Bearings on the sector edges and just out of range.
            case ($urandom_range(0, 6))
                0: a = 0;
                1: a = 900;
                2: a = -900;
                3: a = 1800;
                4: a = -1800;
                5: a = 1801;
                default: a = -1801;
            endcase
            return make_point(a, $urandom_range(0, 1) ? nd : fd, last);
        end
        return make_point(int'($urandom_range(0, 4095)), int'($urandom_range(0, 65535)), last);
    endfunction

    task automatic push_random_scan(int n, bit drain_first);
        for (int i = 0; i < n; i++)
            push_point(draw_point(i == n - 1), drain_first && i == 0);
    endtask

    initial begin
        int  n;
        int  phase_items;
        bit  paused;
        paused = 1'b0;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values in force; a write to an undecoded address must not
        // disturb any register.
        reg_write(REG_UNUSED, 16'hFFFF);

        // Sector edges, threshold distances and stray bearings in one scan.
        push_point(make_point(1, 51, 1'b0), 1'b0);
        push_point(make_point(899, 799, 1'b0), 1'b0);
        push_point(make_point(0, 400, 1'b0), 1'b0);
        push_point(make_point(900, 400, 1'b0), 1'b0);
        push_point(make_point(901, 400, 1'b0), 1'b0);
        push_point(make_point(1799, 400, 1'b0), 1'b0);
        push_point(make_point(1800, 400, 1'b0), 1'b0);
        push_point(make_point(-1799, 0, 1'b0), 1'b0);
        push_point(make_point(-901, 799, 1'b0), 1'b0);
        push_point(make_point(-900, 400, 1'b0), 1'b0);
        push_point(make_point(-1, 400, 1'b0), 1'b0);
        push_point(make_point(-1800, 400, 1'b0), 1'b0);
        push_point(make_point(450, 50, 1'b0), 1'b0);
        push_point(make_point(450, 800, 1'b0), 1'b0);
        push_point(make_point(450, 3000, 1'b0), 1'b0);
        push_point(make_point(450, 3001, 1'b0), 1'b0);
        push_point(make_point(1799, 65535, 1'b0), 1'b0);
        push_point(make_point(2047, 400, 1'b0), 1'b0);
        push_point(make_point(-2048, 400, 1'b0), 1'b0);
        push_point(make_point(1000, 400, 1'b1), 1'b0);
        // Single-point scans: error inside the deadband still updates the
        // previous error.
        push_point(make_point(450, 400, 1'b1), 1'b0);
        push_point(make_point(1350, 65535, 1'b1), 1'b0);
        // Near misses of the zone condition: back count at its limit, front
        // count one short.
        push_scan(30, 41, 0, 0);
        push_scan(1, 40, 0, 0);
        drain();

        // Random scans under several settings, extremes included. Scans stay
        // at 40 points or fewer so the zone flag stays clear here.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: apply_config(RST_MIN_RANGE, RST_NEAR_RADIUS, RST_FAR_RANGE, RST_DEADBAND,
                                RST_PROP_GAIN, RST_DERIV_GAIN, RST_STEER_LIMIT);
                1: apply_config(0, 0, 0, 0, 0, 0, 0);
                2: apply_config(0, 65535, 65535, 0, 65535, 65535, 65535);
                3: apply_config(65535, 65535, 0, 512, 1, 1, 1);
                default: apply_config($urandom_range(0, 200), $urandom_range(300, 2000),
                                      $urandom_range(1000, 8000), $urandom_range(0, 12),
                                      $urandom_range(0, 300), $urandom_range(0, 4000),
                                      $urandom_range(0, 1) ? $urandom_range(0, 2500) : 65535);
            endcase
            phase_items = 0;
            while (phase_items < 75) begin
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
                // Once, hold the sender until every result is out.
                push_random_scan(n, ph == 4 && phase_items >= 30 && !paused);
                if (ph == 4 && phase_items >= 30) paused = 1'b1;
                phase_items += n;
            end
            drain();
        end

        // Enter the zone, then show that the flag sticks; finally saturate
        // the right counter.
        apply_config(RST_MIN_RANGE, RST_NEAR_RADIUS, RST_FAR_RANGE, RST_DEADBAND,
                     RST_PROP_GAIN, RST_DERIV_GAIN, RST_STEER_LIMIT);
        push_scan(29, 41, 0, 0);
        push_scan(0, 0, 1, 0);
        push_scan(0, 0, 514, 0);
        drain();

        if (mismatch_count == 0) begin
            $display("lidar_sector_steering regression: pass");
        end else begin
            $display("lidar_sector_steering regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20000000;
        $display("lidar_sector_steering regression: fail");
        $finish;
    end

endmodule
